### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the point transform core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define HPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define HPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// types and fixed widths shared by the point transform core
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int Q_W        = 32;           // fixed point word
    localparam int PROD_W     = 2 * Q_W;      // one entry times one component
    localparam int PAIR_W     = PROD_W + 1;   // sum of two products
    localparam int SUM_W      = PROD_W + 2;   // exact sum of four products
    localparam int NUM_LANES  = 4;            // one lane per matrix row
    localparam int NUM_COLS   = 4;
    localparam int NUM_STAGES = 5;            // product, pair, total, clip, output
    localparam int CFG_REGS   = 8;
    localparam int CFG_DW     = 64;
    localparam int CFG_LSB    = 3;            // 8-byte register stride
    localparam int CFG_IDX_W  = $clog2(CFG_REGS);
    localparam int CFG_AW     = CFG_IDX_W + CFG_LSB;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic signed [Q_W-1:0] q_t;
    typedef q_t [NUM_COLS-1:0] vec_t;

    // load enables of the lane pipeline
    typedef struct packed {
        logic prod;
        logic pair;
        logic total;
        logic clip;
    } stage_en_t;

    typedef struct packed {
        q_t   value;
        logic sat;
    } lane_res_t;

    typedef lane_res_t [NUM_LANES-1:0] lane_res_vec_t;

endpackage

### rtl/homogeneous_point_transform_4x4_core.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform_4x4_core
// 4x4 matrix times homogeneous tuple, signed fixed point, saturating
// ----------------------------------------------------------------------------
// Multiplies each (x, y, z, w) tuple by a 4x4 matrix of signed fixed-point
// entries (FRAC_BITS fraction bits, Q16.16 by default) held in eight 64-bit
// registers on the APB port, register i at byte address 8*i, entry [r][2h] in
// bits 31:0 and entry [r][2h+1] in bits 63:32 of register 2r+h. Reset loads
// the identity. Each output component is the exact dot product of one row with
// the tuple, floored to the fixed-point grid and clipped to the 32-bit signed
// range; saturated flags that any component was clipped. The block takes one
// transfer per clock while item_stall is low. Four row lanes run side by side
// through a multiplier stage (sixteen 32x32 multipliers), two adder-tree stages
// and a floor/clip stage, and a merge stage loads the output register. A
// stalled output fills the pipeline bubbles first; only when all five stages
// hold items does item_stall rise. Write the matrix only while no item is in
// flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module homogeneous_point_transform_4x4_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // input tuple channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [31:0]           x_in,
    input  logic signed [31:0]           y_in,
    input  logic signed [31:0]           z_in,
    input  logic signed [31:0]           w_in,

    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [31:0]           x_out,
    output logic signed [31:0]           y_out,
    output logic signed [31:0]           z_out,
    output logic signed [31:0]           w_out,
    output logic                         saturated,

    // matrix registers
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hpt_pkg::CFG_AW-1:0]   paddr,
    input  logic [hpt_pkg::CFG_DW-1:0]   pwdata,
    output logic [hpt_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int S = hpt_pkg::NUM_STAGES;

    // stage positions in the valid chain
    localparam int ST_PROD  = 0;
    localparam int ST_PAIR  = 1;
    localparam int ST_TOTAL = 2;
    localparam int ST_CLIP  = 3;
    localparam int ST_OUT   = 4;

    localparam logic [hpt_pkg::Q_W-1:0] ONE_Q = hpt_pkg::Q_W'(1) << FRAC_BITS;

    // identity reset value of register i
    function automatic logic [hpt_pkg::CFG_DW-1:0] identity_word(input int i);
        int row;
        int half;
        logic [hpt_pkg::CFG_DW-1:0] word;
        row  = i >> 1;
        half = row & 1;
        word = '0;
        if ((row >> 1) == (i & 1))
            word = hpt_pkg::CFG_DW'(ONE_Q) << (hpt_pkg::Q_W * half);
        return word;
    endfunction

    logic [hpt_pkg::CFG_DW-1:0] mat_reg [hpt_pkg::CFG_REGS];
    logic [hpt_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic                          cfg_wr;

    logic [S-1:0]  vld_reg;
    logic [S-1:0]  vld_next;
    logic [S-1:0]  rdy;
    logic [S-1:0]  ld;
    logic          item_acc;

    hpt_pkg::stage_en_t     lane_en;
    hpt_pkg::vec_t          tuple;
    hpt_pkg::vec_t          rows [hpt_pkg::NUM_LANES];
    hpt_pkg::lane_res_vec_t lane_res;

    // ------------------------------------------------------------------
    // configuration port, writes land on the access phase
    // ------------------------------------------------------------------
    assign cfg_idx = paddr[hpt_pkg::CFG_AW-1:hpt_pkg::CFG_LSB];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = mat_reg[cfg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpt_pkg::CFG_REGS; i++)
            begin
                mat_reg[i] <= identity_word(i);
            end
        end
        else if (cfg_wr)
        begin
            mat_reg[cfg_idx] <= pwdata;
        end
    end

    // unpack the rows: even column in the low half, odd in the high half
    always_comb
    begin
        for (int r = 0; r < hpt_pkg::NUM_LANES; r++)
        begin
            for (int c = 0; c < hpt_pkg::NUM_COLS; c++)
            begin
                rows[r][c] = mat_reg[2 * r + (c >> 1)][hpt_pkg::Q_W * (c & 1) +: hpt_pkg::Q_W];
            end
        end
    end

    assign tuple[0] = x_in;
    assign tuple[1] = y_in;
    assign tuple[2] = z_in;
    assign tuple[3] = w_in;

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    always_comb
    begin
        rdy[S-1] = !vld_reg[S-1] || !result_stall;
        for (int k = S - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        ld[0]       = rdy[0] && item_valid;
        vld_next[0] = rdy[0] ? item_valid : vld_reg[0];
        for (int k = 1; k < S; k++)
        begin
            ld[k]       = rdy[k] && vld_reg[k-1];
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign item_stall   = !rdy[0];
    assign item_acc     = item_valid && !item_stall;
    assign result_valid = vld_reg[ST_OUT];

    assign lane_en.prod  = ld[ST_PROD];
    assign lane_en.pair  = ld[ST_PAIR];
    assign lane_en.total = ld[ST_TOTAL];
    assign lane_en.clip  = ld[ST_CLIP];

    // ------------------------------------------------------------------
    // one lane per matrix row
    // ------------------------------------------------------------------
    for (genvar r = 0; r < hpt_pkg::NUM_LANES; r++)
    begin : g_lane
        hpt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (lane_en),
            .row   (rows[r]),
            .tuple (tuple),
            .res   (lane_res[r])
        );
    end

    // merge lanes into the output register
    hpt_merge u_merge (
        .clk       (clk),
        .en        (ld[ST_OUT]),
        .lanes     (lane_res),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out),
        .w_out     (w_out),
        .saturated (saturated)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `HPT_ASSERT(a_stall_only_when_full, clk, rst_n, item_stall |-> ((&vld_reg) && result_stall), "input stalled with a bubble in the pipeline")
    `HPT_ASSERT(a_accept_enters, clk, rst_n, item_acc |=> vld_reg[ST_PROD], "accepted transfer did not enter the product stage")
    `HPT_ASSERT(a_sat_is_clipped, clk, rst_n, (result_valid && saturated) |-> (x_out == hpt_pkg::Q_MAX || x_out == hpt_pkg::Q_MIN || y_out == hpt_pkg::Q_MAX || y_out == hpt_pkg::Q_MIN || z_out == hpt_pkg::Q_MAX || z_out == hpt_pkg::Q_MIN || w_out == hpt_pkg::Q_MAX || w_out == hpt_pkg::Q_MIN), "saturated set with no clipped component")
    `HPT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> (vld_reg == '0), "pipeline not empty in reset")

endmodule

### rtl/hpt_lane.sv
// ----------------------------------------------------------------------------
// hpt_lane
// one matrix row dot the tuple: multiply, adder tree, floor and clip
// ----------------------------------------------------------------------------
module hpt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  hpt_pkg::stage_en_t en,
    input  hpt_pkg::vec_t      row,
    input  hpt_pkg::vec_t      tuple,
    output hpt_pkg::lane_res_t res
);

    logic signed [hpt_pkg::PROD_W-1:0] prod_reg [hpt_pkg::NUM_COLS];
    logic signed [hpt_pkg::PAIR_W-1:0] pair_reg [2];
    logic signed [hpt_pkg::SUM_W-1:0]  total_reg;
    hpt_pkg::lane_res_t                res_reg;

    logic signed [hpt_pkg::SUM_W-1:0]          floored;
    logic [hpt_pkg::SUM_W-hpt_pkg::Q_W:0]      top_bits;
    logic                                      over_hi;
    logic                                      over_lo;
    hpt_pkg::lane_res_t                        res_next;

    // products, one 32x32 multiplier per column
    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            for (int c = 0; c < hpt_pkg::NUM_COLS; c++)
            begin
                prod_reg[c] <= hpt_pkg::PROD_W'($signed(row[c])) *
                               hpt_pkg::PROD_W'($signed(tuple[c]));
            end
        end
    end

    // first level of the adder tree
    always_ff @(posedge clk)
    begin
        if (en.pair)
        begin
            pair_reg[0] <= hpt_pkg::PAIR_W'(prod_reg[0]) + hpt_pkg::PAIR_W'(prod_reg[1]);
            pair_reg[1] <= hpt_pkg::PAIR_W'(prod_reg[2]) + hpt_pkg::PAIR_W'(prod_reg[3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.total)
        begin
            total_reg <= hpt_pkg::SUM_W'(pair_reg[0]) + hpt_pkg::SUM_W'(pair_reg[1]);
        end
    end

    // arithmetic shift floors toward minus infinity
    always_comb
    begin
        floored  = total_reg >>> FRAC_BITS;
        top_bits = floored[hpt_pkg::SUM_W-1:hpt_pkg::Q_W-1];
        over_hi  = !top_bits[hpt_pkg::SUM_W-hpt_pkg::Q_W] && (|top_bits);
        over_lo  = top_bits[hpt_pkg::SUM_W-hpt_pkg::Q_W] && !(&top_bits);
        res_next.sat = over_hi || over_lo;
        if (over_hi)
            res_next.value = hpt_pkg::Q_MAX;
        else if (over_lo)
            res_next.value = hpt_pkg::Q_MIN;
        else
            res_next.value = floored[hpt_pkg::Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.clip)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/hpt_merge.sv
// ----------------------------------------------------------------------------
// hpt_merge
// gathers the four lane results into the output register
// ----------------------------------------------------------------------------
module hpt_merge (
    input  logic                   clk,
    input  logic                   en,
    input  hpt_pkg::lane_res_vec_t lanes,
    output hpt_pkg::q_t            x_out,
    output hpt_pkg::q_t            y_out,
    output hpt_pkg::q_t            z_out,
    output hpt_pkg::q_t            w_out,
    output logic                   saturated
);

    hpt_pkg::vec_t comp_reg;
    logic          sat_reg;
    logic          sat_next;

    always_comb
    begin
        sat_next = 1'b0;
        for (int l = 0; l < hpt_pkg::NUM_LANES; l++)
        begin
            sat_next = sat_next | lanes[l].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < hpt_pkg::NUM_LANES; l++)
            begin
                comp_reg[l] <= lanes[l].value;
            end
            sat_reg <= sat_next;
        end
    end

    assign x_out     = comp_reg[0];
    assign y_out     = comp_reg[1];
    assign z_out     = comp_reg[2];
    assign w_out     = comp_reg[3];
    assign saturated = sat_reg;

endmodule

### test/tb_homogeneous_point_transform_4x4_core.sv
// ----------------------------------------------------------------------------
// tb_homogeneous_point_transform_4x4_core
// self-checking bench for the 4x4 homogeneous point transform core
// ----------------------------------------------------------------------------
// Loads a series of matrices over the APB port and reads each register back.
// Tuples are streamed through the valid/stall channels while a scoreboard
// predicts every result: the exact sum of four products per row, floored to
// the fixed-point grid and clipped to the signed 32-bit range. A short
// directed set covers field extremes, points, vectors, flooring of negative
// fractions and clipping at both ends. A random set follows in three idling
// phases, one of them with a long receiver hold that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_homogeneous_point_transform_4x4_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC               = 16;
    localparam int ITEMS_PER_SETTING  = 92;
    localparam int SETTINGS_PER_PHASE = 6;
    localparam int MAT_MODES          = 8;
    localparam int HOLD_CYCLES        = 48;
    localparam int QUIET_LIMIT        = 2000;
    localparam int REPORT_LIMIT       = 10;

    localparam hpt_pkg::q_t ONE_Q  = 32'sd1 <<< FRAC;
    localparam hpt_pkg::q_t HALF_Q = ONE_Q >>> 1;

    // clip bounds at the width of the exact row sum
    localparam logic signed [hpt_pkg::SUM_W+1:0] WIDE_Q_MAX = hpt_pkg::Q_MAX;
    localparam logic signed [hpt_pkg::SUM_W+1:0] WIDE_Q_MIN = hpt_pkg::Q_MIN;

    typedef enum int {
        ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
        ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
    } matrix_reg_t;

    typedef enum int {
        MAT_IDENTITY, MAT_HALF, MAT_SMALL, MAT_FULL,
        MAT_ALL_MAX, MAT_ALL_MIN, MAT_EXTREME_MIX, MAT_ZERO
    } matrix_mode_t;

    typedef hpt_pkg::q_t matrix_t [hpt_pkg::NUM_LANES][hpt_pkg::NUM_COLS];

    typedef struct {
        hpt_pkg::q_t x;
        hpt_pkg::q_t y;
        hpt_pkg::q_t z;
        hpt_pkg::q_t w;
        logic        sat;
    } point_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the matrix registers and the expected results
    // ------------------------------------------------------------------------
    class transform_scoreboard;
        logic [hpt_pkg::CFG_DW-1:0] matrix_regs [hpt_pkg::CFG_REGS];
        point_result_t              expected_points [$];
        int unsigned                mismatches;
        int unsigned                results_checked;
        int unsigned                saturated_seen;

        function new();
            for (int i = 0; i < hpt_pkg::CFG_REGS; i++)
                matrix_regs[i] = '0;
            // reset value is the identity
            matrix_regs[ROW0_COLS01] = {32'h0, ONE_Q};
            matrix_regs[ROW1_COLS01] = {ONE_Q, 32'h0};
            matrix_regs[ROW2_COLS23] = {32'h0, ONE_Q};
            matrix_regs[ROW3_COLS23] = {ONE_Q, 32'h0};
            mismatches      = 0;
            results_checked = 0;
            saturated_seen  = 0;
        endfunction

        function void load_reg(matrix_reg_t idx, logic [hpt_pkg::CFG_DW-1:0] value);
            matrix_regs[idx] = value;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function hpt_pkg::q_t matrix_entry(int row, int col);
            logic [hpt_pkg::CFG_DW-1:0] pair;
            pair = matrix_regs[2 * row + col / 2];
            return (col % 2 == 1) ? hpt_pkg::q_t'(pair[63:32]) : hpt_pkg::q_t'(pair[31:0]);
        endfunction

        // exact dot product of one row, floored then clipped
        function hpt_pkg::lane_res_t row_dot(int row, hpt_pkg::vec_t tuple);
            logic signed [hpt_pkg::PROD_W-1:0] product;
            logic signed [hpt_pkg::SUM_W+1:0]  total;
            logic signed [hpt_pkg::SUM_W+1:0]  floored;
            hpt_pkg::lane_res_t                res;
            total = '0;
            for (int c = 0; c < hpt_pkg::NUM_COLS; c++)
            begin
                product = matrix_entry(row, c) * $signed(tuple[c]);
                total   = total + product;
            end
            floored = total >>> FRAC;
            res.sat = 1'b0;
            if (floored > WIDE_Q_MAX)
            begin
                res.value = hpt_pkg::Q_MAX;
                res.sat   = 1'b1;
            end
            else if (floored < WIDE_Q_MIN)
            begin
                res.value = hpt_pkg::Q_MIN;
                res.sat   = 1'b1;
            end
            else
                res.value = floored[hpt_pkg::Q_W-1:0];
            return res;
        endfunction

        function void note_tuple(hpt_pkg::vec_t tuple);
            hpt_pkg::lane_res_t lane [hpt_pkg::NUM_LANES];
            point_result_t      exp;
            for (int r = 0; r < hpt_pkg::NUM_LANES; r++)
                lane[r] = row_dot(r, tuple);
            exp.x   = lane[0].value;
            exp.y   = lane[1].value;
            exp.z   = lane[2].value;
            exp.w   = lane[3].value;
            exp.sat = lane[0].sat | lane[1].sat | lane[2].sat | lane[3].sat;
            expected_points.push_back(exp);
        endfunction

        function void check_result(point_result_t got);
            point_result_t exp;
            results_checked++;
            if (got.sat === 1'b1)
                saturated_seen++;
            if (expected_points.size() == 0)
            begin
                flag($sformatf("result x=%h y=%h z=%h w=%h sat=%b with no tuple waiting",
                               got.x, got.y, got.z, got.w, got.sat));
                return;
            end
            exp = expected_points.pop_front();
            if (got.x !== exp.x || got.y !== exp.y || got.z !== exp.z ||
                got.w !== exp.w || got.sat !== exp.sat)
                flag($sformatf({"expected x=%h y=%h z=%h w=%h sat=%b, ",
                                "got x=%h y=%h z=%h w=%h sat=%b"},
                               exp.x, exp.y, exp.z, exp.w, exp.sat,
                               got.x, got.y, got.z, got.w, got.sat));
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and instance
    // ------------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_stall;
    hpt_pkg::q_t                x_in;
    hpt_pkg::q_t                y_in;
    hpt_pkg::q_t                z_in;
    hpt_pkg::q_t                w_in;
    logic                       result_valid;
    logic                       result_stall;
    hpt_pkg::q_t                x_out;
    hpt_pkg::q_t                y_out;
    hpt_pkg::q_t                z_out;
    hpt_pkg::q_t                w_out;
    logic                       saturated;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [hpt_pkg::CFG_AW-1:0] paddr;
    logic [hpt_pkg::CFG_DW-1:0] pwdata;
    logic [hpt_pkg::CFG_DW-1:0] prdata;
    logic                       pready;

    transform_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_request;
    int unsigned tuples_accepted;
    int unsigned matrix_loads;
    int unsigned quiet_cycles;

    homogeneous_point_transform_4x4_core #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .x_in         (x_in),
        .y_in         (y_in),
        .z_in         (z_in),
        .w_in         (w_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .x_out        (x_out),
        .y_out        (y_out),
        .z_out        (z_out),
        .w_out        (w_out),
        .saturated    (saturated),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // x sits in element 0, w in element 3
    function automatic hpt_pkg::vec_t pack_tuple(hpt_pkg::q_t x, hpt_pkg::q_t y,
                                                 hpt_pkg::q_t z, hpt_pkg::q_t w);
        return {w, z, y, x};
    endfunction

    // magnitude up to four units, so products stay well inside range
    function automatic hpt_pkg::q_t small_q();
        return hpt_pkg::q_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic hpt_pkg::q_t extreme_q();
        case ($urandom_range(0, 6))
            0:       return hpt_pkg::Q_MAX;
            1:       return hpt_pkg::Q_MIN;
            2:       return '0;
            3:       return ONE_Q;
            4:       return -ONE_Q;
            5:       return hpt_pkg::q_t'(1);
            default: return hpt_pkg::q_t'(-1);
        endcase
    endfunction

    function automatic matrix_t make_matrix(matrix_mode_t mode);
        matrix_t m;
        for (int r = 0; r < hpt_pkg::NUM_LANES; r++)
        begin
            for (int c = 0; c < hpt_pkg::NUM_COLS; c++)
            begin
                case (mode)
                    MAT_IDENTITY:    m[r][c] = (r == c) ? ONE_Q : '0;
                    MAT_HALF:        m[r][c] = (r == c) ? HALF_Q : -HALF_Q;
                    MAT_SMALL:       m[r][c] = small_q();
                    MAT_FULL:        m[r][c] = hpt_pkg::q_t'($urandom);
                    MAT_ALL_MAX:     m[r][c] = hpt_pkg::Q_MAX;
                    MAT_ALL_MIN:     m[r][c] = hpt_pkg::Q_MIN;
                    MAT_EXTREME_MIX: m[r][c] = extreme_q();
                    default:         m[r][c] = '0;
                endcase
            end
        end
        return m;
    endfunction

    // full-range tuples, small values, extremes, points and vectors
    function automatic hpt_pkg::vec_t random_tuple();
        hpt_pkg::vec_t t;
        int unsigned   pick;
        pick = $urandom_range(0, 99);
        for (int c = 0; c < hpt_pkg::NUM_COLS; c++)
        begin
            if (pick < 40)
                t[c] = hpt_pkg::q_t'($urandom);
            else if (pick < 65)
                t[c] = small_q();
            else if (pick < 80)
                t[c] = extreme_q();
            else
                t[c] = small_q();
        end
        if (pick >= 90)
            t[3] = '0;
        else if (pick >= 80)
            t[3] = ONE_Q;
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // monitors: both sides sampled at the rising edge
    // ------------------------------------------------------------------------

    // every accepted input transfer gets its expected result queued
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            sb.note_tuple(pack_tuple(x_in, y_in, z_in, w_in));
            tuples_accepted++;
        end
    end

    // every accepted result transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        point_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.x   = x_out;
            got.y   = y_out;
            got.z   = z_out;
            got.w   = w_out;
            got.sat = saturated;
            sb.check_result(got);
        end
    end

    // watchdog: ends the run once nothing has moved for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, sb.pending());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall per cycle, plus one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                // keep stalling while the sender fills the pipeline behind us
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // drivers: all inputs change at the falling edge
    // ------------------------------------------------------------------------

    // entered and left at a falling edge; valid stays high for a following transfer
    task automatic send_tuple(input hpt_pkg::vec_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        x_in       <= t[0];
        y_in       <= t[1];
        z_in       <= t[2];
        w_in       <= t[3];
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write one register, then read it back; psel is left high for the caller
    task automatic write_matrix_reg(input matrix_reg_t idx,
                                    input logic [hpt_pkg::CFG_DW-1:0] value);
        logic [hpt_pkg::CFG_DW-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hpt_pkg::CFG_AW'(int'(idx) << hpt_pkg::CFG_LSB);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.load_reg(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        if (readback !== value)
            sb.flag($sformatf("register %s read back %h, written %h",
                              idx.name(), readback, value));
        @(negedge clk);
    endtask

    // drain the pipeline, then write all eight registers
    task automatic load_matrix(input matrix_t m);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        // every transfer maps to a result, so an empty queue means the block is idle
        @(negedge clk);
        for (int r = 0; r < hpt_pkg::NUM_LANES; r++)
        begin
            for (int h = 0; h < 2; h++)
                write_matrix_reg(matrix_reg_t'(2 * r + h), {m[r][2 * h + 1], m[r][2 * h]});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        matrix_loads++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        x_in            = '0;
        y_in            = '0;
        z_in            = '0;
        w_in            = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_request    = 1'b0;
        tuples_accepted = 0;
        matrix_loads    = 0;
        quiet_cycles    = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity out of reset: outputs equal inputs, including the extremes
        send_tuple(pack_tuple('0, '0, '0, '0));
        send_tuple(pack_tuple(hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX));
        send_tuple(pack_tuple(hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN));
        send_tuple(pack_tuple(ONE_Q, 2 * ONE_Q, -3 * ONE_Q, ONE_Q));
        send_tuple(pack_tuple(hpt_pkg::q_t'(-1), hpt_pkg::q_t'(1), hpt_pkg::Q_MAX, '0));
        send_tuple(pack_tuple(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));

        // largest positive entries: clipping at the top and at the bottom
        load_matrix(make_matrix(MAT_ALL_MAX));
        send_tuple(pack_tuple(hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX));
        send_tuple(pack_tuple(hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN));
        send_tuple(pack_tuple(hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN));
        send_tuple(pack_tuple(hpt_pkg::q_t'(1), '0, '0, '0));

        // most negative entries: min times min gives the largest exact sum
        load_matrix(make_matrix(MAT_ALL_MIN));
        send_tuple(pack_tuple(hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN));
        send_tuple(pack_tuple(hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX));
        send_tuple(pack_tuple(hpt_pkg::q_t'(-1), '0, '0, ONE_Q));

        // half-unit entries: flooring of odd and negative values
        load_matrix(make_matrix(MAT_HALF));
        send_tuple(pack_tuple(hpt_pkg::q_t'(-1), '0, '0, '0));
        send_tuple(pack_tuple(hpt_pkg::q_t'(1), '0, '0, '0));
        send_tuple(pack_tuple(hpt_pkg::q_t'(3), hpt_pkg::q_t'(-3),
                              hpt_pkg::q_t'(5), hpt_pkg::q_t'(-5)));
        send_tuple(pack_tuple(ONE_Q + HALF_Q, -2 * ONE_Q - (HALF_Q >>> 1), HALF_Q, ONE_Q));
        send_tuple(pack_tuple(-ONE_Q, HALF_Q, hpt_pkg::q_t'(-7), '0));

        // random part: three idling phases, several matrices in each
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 86;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int setting = 0; setting < SETTINGS_PER_PHASE; setting++)
            begin
                load_matrix(make_matrix(matrix_mode_t'(
                    (phase * SETTINGS_PER_PHASE + setting) % MAT_MODES)));
                for (int n = 0; n < ITEMS_PER_SETTING; n++)
                begin
                    // back-to-back phase: hold the output so the block backs up
                    if (phase == 2 && setting == 1 && n == 20)
                        hold_request = 1'b1;
                    send_tuple(random_tuple());
                end
            end
        end

        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        // let any stray result show up before closing
        repeat (2 * hpt_pkg::NUM_STAGES) @(posedge clk);

        $display("run covered %0d tuples over %0d matrix loads, %0d results checked, %0d clipped",
                 tuples_accepted, matrix_loads, sb.results_checked, sb.saturated_seen);
        $display({"idling: light sender/heavy receiver, reversed, ",
                  "then back-to-back with a %0d-cycle hold"}, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
